>>> hdl/trtq_pkg.sv
// Package for the retransmit timer queue: operation codes, result actions,
// register indexes and reset values. No dependencies.
package trtq_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ARM     = 2'd1,
    OP_ACK     = 2'd2,
    OP_ARM_TW  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_RESEND = 2'd1,
    ACT_GIVEUP = 2'd2
  } act_t;

  localparam logic [1:0] REG_TICK_INTERVAL    = 2'd0;
  localparam logic [1:0] REG_INITIAL_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_TIMEWAIT_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_MAX_RETRIES      = 2'd3;

  localparam logic [19:0] TICK_INTERVAL_RST    = 20'd100000;
  localparam logic [23:0] INITIAL_TIMEOUT_RST  = 24'd200000;
  localparam logic [26:0] TIMEWAIT_TIMEOUT_RST = 27'd2000000;
  localparam logic [2:0]  MAX_RETRIES_RST      = 3'd3;

  // One accepted item as it sits in the command queue.
  typedef struct packed {
    op_t         op;
    logic [7:0]  conn;
    logic [31:0] sseq;
    logic [31:0] aseq;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic        tw_done;
    logic [7:0]  tw_conn;
    act_t        action;
    logic [7:0]  r_conn;
    logic [31:0] r_seq;
    logic [2:0]  r_cnt;
  } res_t;

endpackage

>>> hdl/trtq_front.sv
// Front part: accepts items into a two-entry command queue.
// Depends on trtq_pkg.
module trtq_front
  import trtq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmd_t       in_cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  logic push;
  logic pop;

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> !push) else $error("command queue overflow");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3) else $error("command queue count out of range");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && fill == 2'd0) |=> cmd_valid) else $error("lost item");
`endif

endmodule

>>> hdl/trtq_back.sv
// Back part: timer queue memory, time-wait timer and the tick/ack walker.
// Depends on trtq_pkg.
module trtq_back
  import trtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic [19:0] tick_interval,
  input  logic [23:0] initial_timeout,
  input  logic [26:0] timewait_timeout,
  input  logic [2:0]  max_retries,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_RD,
    S_TICK_EV,
    S_ACK_RD,
    S_ACK_EV,
    S_OUT
  } state_t;

  state_t state;

  logic [31:0] mem_seq  [QUEUE_DEPTH];
  logic [31:0] mem_rem  [QUEUE_DEPTH];
  logic [2:0]  mem_ret  [QUEUE_DEPTH];
  logic [7:0]  mem_conn [QUEUE_DEPTH];

  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [IW-1:0] slot;

  logic          wait_armed;
  logic [31:0]   wait_rem;
  logic [7:0]    wait_conn;

  cmd_t        cur;
  logic [31:0] rd_seq;
  logic [31:0] rd_rem;
  logic [2:0]  rd_ret;
  logic [7:0]  rd_conn;

  logic [31:0] dec_rem;
  logic [31:0] tw_rem_next;
  logic [31:0] reload;
  logic [IW-1:0] tail_slot;
  logic [IW:0]   tail_sum;
  logic [IW:0]   slot_sum;
  logic          tw_fire;
  logic          q_full;

  assign cmd_ready = (state == S_IDLE) && !res_valid;

  assign dec_rem = (rd_rem > {12'd0, tick_interval}) ? rd_rem - {12'd0, tick_interval} : 32'd0;
  assign tw_rem_next = (wait_rem > {12'd0, tick_interval}) ?
                       wait_rem - {12'd0, tick_interval} : 32'd0;
  assign reload = {8'd0, initial_timeout} << rd_ret;
  assign tw_fire = wait_armed && (tw_rem_next == 32'd0);
  assign q_full  = (count == CW'(QUEUE_DEPTH));

  // Ring index arithmetic; values stay below twice the depth.
  assign tail_sum  = {1'b0, head} + (IW+1)'(count);
  assign tail_slot = (tail_sum >= (IW+1)'(QUEUE_DEPTH)) ?
                     IW'(tail_sum - (IW+1)'(QUEUE_DEPTH)) : IW'(tail_sum);
  assign slot_sum  = {1'b0, head} + (IW+1)'(pos);
  assign slot      = (slot_sum >= (IW+1)'(QUEUE_DEPTH)) ?
                     IW'(slot_sum - (IW+1)'(QUEUE_DEPTH)) : IW'(slot_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      pos        <= '0;
      wait_armed <= 1'b0;
      wait_rem   <= 32'd0;
      wait_conn  <= 8'd0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cur <= cmd;
            pos <= '0;
            case (cmd.op)
              OP_TICK: begin
                wait_rem <= tw_rem_next;
                if (tw_fire) begin
                  wait_armed <= 1'b0;
                end
                res <= '{status: 1'b0, tw_done: tw_fire,
                         tw_conn: tw_fire ? wait_conn : 8'd0, action: ACT_NONE,
                         r_conn: 8'd0, r_seq: 32'd0, r_cnt: 3'd0};
                state <= S_TICK_RD;
              end
              OP_ARM: begin
                res <= '{status: q_full, tw_done: 1'b0, tw_conn: 8'd0,
                         action: ACT_NONE, r_conn: 8'd0, r_seq: 32'd0, r_cnt: 3'd0};
                if (!q_full) begin
                  mem_seq[tail_slot]  <= cmd.sseq;
                  mem_rem[tail_slot]  <= {8'd0, initial_timeout};
                  mem_ret[tail_slot]  <= 3'd0;
                  mem_conn[tail_slot] <= cmd.conn;
                  count <= count + 1'b1;
                end
                state <= S_OUT;
              end
              OP_ACK: begin
                res   <= '0;
                state <= S_ACK_RD;
              end
              OP_ARM_TW: begin
                res        <= '0;
                wait_armed <= 1'b1;
                wait_rem   <= {5'd0, timewait_timeout};
                wait_conn  <= cmd.conn;
                state      <= S_OUT;
              end
              default: begin
                res   <= '0;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_TICK_RD: begin
          if (pos == count) begin
            state <= S_OUT;
          end else begin
            rd_seq  <= mem_seq[slot];
            rd_rem  <= mem_rem[slot];
            rd_ret  <= mem_ret[slot];
            rd_conn <= mem_conn[slot];
            state   <= S_TICK_EV;
          end
        end
        S_TICK_EV: begin
          if (dec_rem != 32'd0) begin
            mem_rem[slot] <= dec_rem;
            pos   <= pos + 1'b1;
            state <= S_TICK_RD;
          end else begin
            if (rd_ret >= max_retries) begin
              res <= '{status: res.status, tw_done: res.tw_done, tw_conn: res.tw_conn,
                       action: ACT_GIVEUP, r_conn: rd_conn, r_seq: rd_seq,
                       r_cnt: rd_ret};
              mem_rem[slot] <= 32'd0;
            end else begin
              res <= '{status: res.status, tw_done: res.tw_done, tw_conn: res.tw_conn,
                       action: ACT_RESEND, r_conn: rd_conn, r_seq: rd_seq,
                       r_cnt: rd_ret + 3'd1};
              mem_rem[slot] <= reload;
              mem_ret[slot] <= rd_ret + 3'd1;
            end
            state <= S_OUT;
          end
        end
        S_ACK_RD: begin
          if (count == '0) begin
            state <= S_OUT;
          end else begin
            rd_seq <= mem_seq[head];
            state  <= S_ACK_EV;
          end
        end
        S_ACK_EV: begin
          if (rd_seq <= cur.aseq) begin
            head  <= (head == IW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
            count <= count - 1'b1;
            state <= S_ACK_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("queue count above depth");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> res_valid) else $error("result not posted");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !cmd_ready) else $error("item taken with result pending");
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_valid && cmd_ready && cmd.op == OP_ARM &&
     count == CW'(QUEUE_DEPTH)) |=> $stable(count)) else $error("full arm changed queue");
`endif

endmodule

>>> hdl/tcp_retransmit_timer_queue_top.sv
// Per item: an arm or time-wait arm goes straight to its result; a tick walks the
// entries from the head until one expires or all are walked; an ack pops entries
// from the head while their sequence is at most the acked one.
// One item at a time in the back part, which takes none while a result is pending;
// a two-entry command queue in front accepts meanwhile. Synchronous reset empties
// the queue, disarms time-wait and loads register defaults; no clearing pass.
// Top level of the retransmit timer queue. Depends on trtq_pkg, trtq_front,
// trtq_back.
module tcp_retransmit_timer_queue_top
  import trtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [26:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  conn_id,
  input  logic [31:0] sent_seq,
  input  logic [31:0] acked_seq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        timewait_done,
  output logic [7:0]  timewait_conn,
  output logic [1:0]  retrans_action,
  output logic [7:0]  retrans_conn,
  output logic [31:0] retrans_seq,
  output logic [2:0]  retry_count
);

  logic [19:0] tick_interval;
  logic [23:0] initial_timeout;
  logic [26:0] timewait_timeout;
  logic [2:0]  max_retries;

  cmd_t in_cmd;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_interval    <= TICK_INTERVAL_RST;
      initial_timeout  <= INITIAL_TIMEOUT_RST;
      timewait_timeout <= TIMEWAIT_TIMEOUT_RST;
      max_retries      <= MAX_RETRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICK_INTERVAL:    tick_interval    <= cfg_data[19:0];
        REG_INITIAL_TIMEOUT:  initial_timeout  <= cfg_data[23:0];
        REG_TIMEWAIT_TIMEOUT: timewait_timeout <= cfg_data;
        REG_MAX_RETRIES:      max_retries      <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_cmd.op   = op_t'(operation);
  assign in_cmd.conn = conn_id;
  assign in_cmd.sseq = sent_seq;
  assign in_cmd.aseq = acked_seq;

  trtq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  trtq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd),
    .tick_interval    (tick_interval),
    .initial_timeout  (initial_timeout),
    .timewait_timeout (timewait_timeout),
    .max_retries      (max_retries),
    .res_valid        (out_valid),
    .res_ready        (out_ready),
    .res              (res)
  );

  assign status         = res.status;
  assign timewait_done  = res.tw_done;
  assign timewait_conn  = res.tw_conn;
  assign retrans_action = res.action;
  assign retrans_conn   = res.r_conn;
  assign retrans_seq    = res.r_seq;
  assign retry_count    = res.r_cnt;

endmodule

>>> tb/tcp_retransmit_timer_queue_top_tb.sv
// Testbench for the retransmit timer queue: drives random and directed items,
// predicts each result in a scoreboard class and compares. Depends on trtq_pkg
// and tcp_retransmit_timer_queue_top.
`timescale 1ns / 1ps
module tcp_retransmit_timer_queue_top_tb
  import trtq_pkg::*;
();

  localparam int Depth = 16;

  class timer_scoreboard;
    logic [19:0] tick_iv;
    logic [23:0] init_to;
    logic [26:0] tw_to;
    logic [2:0]  retry_limit;
    logic [31:0] seq_mem [Depth];
    logic [31:0] remain_mem [Depth];
    logic [2:0]  retry_mem [Depth];
    logic [7:0]  conn_mem [Depth];
    int          head;
    int          count;
    bit          tw_armed;
    logic [31:0] tw_remain;
    logic [7:0]  tw_owner;
    res_t        pending_results[$];
    int          errors;

    function new();
      tick_iv = TICK_INTERVAL_RST;
      init_to = INITIAL_TIMEOUT_RST;
      tw_to = TIMEWAIT_TIMEOUT_RST;
      retry_limit = MAX_RETRIES_RST;
      head = 0;
      count = 0;
      tw_armed = 0;
      tw_remain = '0;
      tw_owner = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [26:0] val);
      case (idx)
        REG_TICK_INTERVAL:    tick_iv = val[19:0];
        REG_INITIAL_TIMEOUT:  init_to = val[23:0];
        REG_TIMEWAIT_TIMEOUT: tw_to = val;
        REG_MAX_RETRIES:      retry_limit = val[2:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] sat_sub(logic [31:0] a, logic [31:0] b);
      return (a > b) ? a - b : 32'd0;
    endfunction

    function void note_item(cmd_t c);
      res_t r;
      int   s;
      r = '0;
      r.action = ACT_NONE;
      case (c.op)
        OP_TICK: begin
          tw_remain = sat_sub(tw_remain, {12'd0, tick_iv});
          if (tw_armed && tw_remain == 0) begin
            tw_armed = 0;
            r.tw_done = 1;
            r.tw_conn = tw_owner;
          end
          for (int p = 0; p < count; p++) begin
            s = (head + p) % Depth;
            remain_mem[s] = sat_sub(remain_mem[s], {12'd0, tick_iv});
            if (remain_mem[s] != 0) continue;
            r.r_conn = conn_mem[s];
            r.r_seq = seq_mem[s];
            if (retry_mem[s] >= retry_limit) begin
              r.action = ACT_GIVEUP;
              r.r_cnt = retry_mem[s];
            end else begin
              r.action = ACT_RESEND;
              remain_mem[s] = {8'd0, init_to} << retry_mem[s];
              retry_mem[s] = retry_mem[s] + 3'd1;
              r.r_cnt = retry_mem[s];
            end
            break;
          end
        end
        OP_ARM: begin
          if (count >= Depth) r.status = 1;
          else begin
            s = (head + count) % Depth;
            seq_mem[s] = c.sseq;
            remain_mem[s] = {8'd0, init_to};
            retry_mem[s] = '0;
            conn_mem[s] = c.conn;
            count++;
          end
        end
        OP_ACK: begin
          while (count > 0 && seq_mem[head] <= c.aseq) begin
            head = (head + 1) % Depth;
            count--;
          end
        end
        default: begin
          tw_armed = 1;
          tw_remain = {5'd0, tw_to};
          tw_owner = c.conn;
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d got %0d", want.status, got.status); errors++;
      end
      if (got.tw_done !== want.tw_done) begin
        $error("timewait_done expected %0d got %0d", want.tw_done, got.tw_done); errors++;
      end
      if (got.tw_conn !== want.tw_conn) begin
        $error("timewait_conn expected %0d got %0d", want.tw_conn, got.tw_conn); errors++;
      end
      if (got.action !== want.action) begin
        $error("retrans_action expected %0d got %0d", want.action, got.action); errors++;
      end
      if (got.r_conn !== want.r_conn) begin
        $error("retrans_conn expected %0d got %0d", want.r_conn, got.r_conn); errors++;
      end
      if (got.r_seq !== want.r_seq) begin
        $error("retrans_seq expected %0h got %0h", want.r_seq, got.r_seq); errors++;
      end
      if (got.r_cnt !== want.r_cnt) begin
        $error("retry_count expected %0d got %0d", want.r_cnt, got.r_cnt); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [26:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  operation = '0;
  logic [7:0]  conn_id = '0;
  logic [31:0] sent_seq = '0;
  logic [31:0] acked_seq = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        status;
  logic        timewait_done;
  logic [7:0]  timewait_conn;
  logic [1:0]  retrans_action;
  logic [7:0]  retrans_conn;
  logic [31:0] retrans_seq;
  logic [2:0]  retry_count;

  int send_idle_pct = 27;
  int recv_idle_pct = 86;
  timer_scoreboard sb;

  tcp_retransmit_timer_queue_top DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Receiver: ready changes on the falling edge, results are taken on the rising one.
  always @(negedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    res_t got;
    if (!rst && out_valid && out_ready) begin
      got.status = status;
      got.tw_done = timewait_done;
      got.tw_conn = timewait_conn;
      got.action = act_t'(retrans_action);
      got.r_conn = retrans_conn;
      got.r_seq = retrans_seq;
      got.r_cnt = retry_count;
      sb.check_result(got);
    end
  end

  // One write per call; the enable drops again before the call returns.
  task automatic config_write(logic [1:0] idx, logic [26:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // Valid stays high into the next item when there is no idle gap; drain()
  // drops it after the last one.
  task automatic send_item(op_t op, logic [7:0] conn, logic [31:0] sseq,
                           logic [31:0] aseq);
    cmd_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    c.op = op;
    c.conn = conn;
    c.sseq = sseq;
    c.aseq = aseq;
    in_valid <= 1;
    operation <= op;
    conn_id <= conn;
    sent_seq <= sseq;
    acked_seq <= aseq;
    do @(posedge clk); while (!in_ready);
    sb.note_item(c);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Mostly ticks and arms with rising sequence numbers, so timers
  // expire, back off and give up; acks cover partial and full pops.
  task automatic random_items(int n);
    logic [31:0] seq_base;
    int k;
    seq_base = $urandom;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 35) begin
        seq_base = seq_base + $urandom_range(1, 3000);
        send_item(OP_ARM, 8'($urandom), ($urandom_range(9) == 0) ? $urandom : seq_base,
                  $urandom);
      end else if (k < 75) send_item(OP_TICK, 8'($urandom), $urandom, $urandom);
      else if (k < 90)
        send_item(OP_ACK, 8'($urandom), $urandom,
                  ($urandom_range(4) == 0) ? $urandom : seq_base - $urandom_range(6000));
      else send_item(OP_ARM_TW, 8'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: registers set first, then a full queue, acks and expiry cases.
    config_write(REG_TICK_INTERVAL, 27'd100000);
    config_write(REG_INITIAL_TIMEOUT, 27'd200000);
    config_write(REG_TIMEWAIT_TIMEOUT, 27'd150000);
    config_write(REG_MAX_RETRIES, 27'd1);
    send_item(OP_ACK, 8'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_ARM, 8'hFF, 32'hFFFF_FFFF, 32'd0);
    for (int i = 0; i < 16; i++) send_item(OP_ARM, i[7:0], 32'(i), 32'hFFFF_FFFF);
    send_item(OP_ARM_TW, 8'hA5, 32'd0, 32'd0);
    send_item(OP_TICK, 8'd0, 32'd0, 32'd0);
    send_item(OP_TICK, 8'd0, 32'd0, 32'd0);
    send_item(OP_TICK, 8'd0, 32'd0, 32'd0);
    send_item(OP_TICK, 8'd0, 32'd0, 32'd0);
    send_item(OP_ACK, 8'd0, 32'd0, 32'd4);
    send_item(OP_ACK, 8'd0, 32'd0, 32'hFFFF_FFFF);
    drain();

    // Zero tick interval and a zero retry limit: the register extremes.
    config_write(REG_TICK_INTERVAL, 27'd0);
    config_write(REG_MAX_RETRIES, 27'd0);
    config_write(REG_INITIAL_TIMEOUT, 27'd1);
    config_write(REG_TIMEWAIT_TIMEOUT, 27'h7FF_FFFF);
    random_items(40);
    drain();

    config_write(REG_TICK_INTERVAL, 27'hF_FFFF);
    config_write(REG_INITIAL_TIMEOUT, 27'hFF_FFFF);
    config_write(REG_MAX_RETRIES, 27'd7);
    config_write(REG_TIMEWAIT_TIMEOUT, 27'd1);
    random_items(100);
    drain();

    send_idle_pct = 86;
    recv_idle_pct = 27;
    config_write(REG_TICK_INTERVAL, 27'd3);
    config_write(REG_INITIAL_TIMEOUT, 27'd5);
    config_write(REG_MAX_RETRIES, 27'd6);
    config_write(REG_TIMEWAIT_TIMEOUT, 27'd10);
    random_items(130);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    config_write(REG_TICK_INTERVAL, 27'd40000);
    config_write(REG_INITIAL_TIMEOUT, 27'd100000);
    config_write(REG_MAX_RETRIES, 27'd2);
    random_items(130);
    drain();

    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
hdl/trtq_pkg.sv
hdl/trtq_front.sv
hdl/trtq_back.sv
hdl/tcp_retransmit_timer_queue_top.sv
tb/tcp_retransmit_timer_queue_top_tb.sv
